FILE: sv/cbac_pkg.sv
// ----------------------------------------------------------------------------
// cbac_pkg
// Types, codes and constants shared by the camera bus accessory controller.
// ----------------------------------------------------------------------------
package cbac_pkg;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_POWER_PRESS   = 2'd0,
        REG_CMD_TIMEOUT   = 2'd1,
        REG_PROTO_VERSION = 2'd2
    } reg_index_t;

    // Register reset values
    localparam logic [15:0] POWER_PRESS_RESET   = 16'd333;
    localparam logic [15:0] CMD_TIMEOUT_RESET   = 16'd667;
    localparam logic [7:0]  PROTO_VERSION_RESET = 8'd0;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Frame and protocol constants
    localparam logic [7:0]  FRAME_START   = 8'h03;
    localparam logic [7:0]  CHAR_V        = 8'h76;
    localparam logic [7:0]  CHAR_S        = 8'h73;
    localparam logic [7:0]  RSP_OK_LEAD   = 8'd2;
    localparam logic [7:0]  RSP_OK_CODE   = 8'd0;
    localparam logic [7:0]  RSP_FAIL_BYTE = 8'd1;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [1:0]  RX_KEEP       = 2'd3;
    localparam logic [1:0]  PSTAT_WAIT    = 2'd2;

    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_SEND      = 3'd1,
        FUNC_POWER     = 3'd2,
        FUNC_ADDRESSED = 3'd3,
        FUNC_RX_BYTE   = 3'd4,
        FUNC_STOP      = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_PWR_REQ   = 3'd1,
        MODE_PWR_WAIT  = 3'd2,
        MODE_CMD_WAIT  = 3'd3,
        MODE_CMD_RESP  = 3'd4,
        MODE_RSP_READY = 3'd5,
        MODE_RSP_DONE  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        RES_UNKNOWN = 2'd0,
        RES_SUCCESS = 2'd1,
        RES_TIMEOUT = 2'd2
    } result_code_t;

    // Input item
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] command_first_char;
        logic [7:0] command_second_char;
        logic [7:0] command_argument;
        logic       read_direction;
        logic [7:0] received_byte;
        logic       bus_busy;
        logic       power_sense;
    } item_t;

    // Result item
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       last_of_run;
        logic       accepted;
        logic       request_line;
        logic       power_button_pressed;
        logic [1:0] power_status;
        logic [1:0] last_result;
        logic       ready_for_command;
        logic [2:0] control_state;
    } result_t;

    // Status shared by every result of one item
    typedef struct packed {
        logic       accepted;
        logic       request_line;
        logic       power_button_pressed;
        logic [1:0] power_status;
        logic [1:0] last_result;
        logic       ready_for_command;
        logic [2:0] control_state;
    } status_t;

    // Work handed from front to back: bytes to send plus status
    typedef struct packed {
        logic [3:0][7:0] tx_bytes;
        logic [2:0]      byte_count;
        status_t         status;
    } run_t;

    // Configuration values seen by the front
    typedef struct packed {
        logic [15:0] power_press_ticks;
        logic [15:0] command_timeout_ticks;
        logic [7:0]  protocol_version;
    } cfg_t;

endpackage

FILE: sv/cbac_front.sv
// ----------------------------------------------------------------------------
// cbac_front
// Accepts items, runs the control state machine and builds one run per item.
// ----------------------------------------------------------------------------
module cbac_front (
    input  logic           clk,
    input  logic           rst_n,
    input  cbac_pkg::cfg_t cfg,
    input  logic           item_valid,
    output logic           item_stall,
    input  cbac_pkg::item_t item,
    input  logic           queue_full,
    output logic           run_push,
    output cbac_pkg::run_t run
);
    import cbac_pkg::*;

    mode_t        mode_reg, mode_next;
    logic [15:0]  tick_reg, tick_next;
    result_code_t result_reg, result_next;
    logic         stop_reg, stop_next;
    logic [1:0]   rx_count_reg, rx_count_next;
    logic         request_reg, request_next;
    logic         button_reg, button_next;
    logic [7:0]   rx_bytes_reg [3];
    logic         rx_write;

    logic         accept;
    logic [15:0]  tick_inc;
    logic         name_match;
    logic         acc;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign run_push   = accept;

    // saturating tick counter increment
    assign tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 16'd1;

    // "vs" query check; missing or out-of-length chars mismatch
    assign name_match = (rx_count_reg >= 2'd2) && (rx_bytes_reg[0] >= 8'd1)
                     && (rx_bytes_reg[1] == CHAR_V)
                     && (rx_count_reg >= 2'd3) && (rx_bytes_reg[0] >= 8'd2)
                     && (rx_bytes_reg[2] == CHAR_S);

    // next state and run contents
    always_comb
    begin
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        result_next   = result_reg;
        stop_next     = stop_reg;
        rx_count_next = rx_count_reg;
        request_next  = request_reg;
        button_next   = button_reg;
        rx_write      = 1'b0;
        acc           = 1'b0;
        run.tx_bytes   = '0;
        run.byte_count = 3'd0;

        case (item.func)
            FUNC_TICK:
            begin
                unique case (mode_reg)
                    MODE_PWR_REQ:
                    begin
                        button_next = 1'b1;
                        tick_next   = 16'd0;
                        mode_next   = MODE_PWR_WAIT;
                    end
                    MODE_PWR_WAIT:
                    begin
                        tick_next = tick_inc;
                        if (tick_reg > cfg.power_press_ticks)
                        begin
                            button_next = 1'b0;
                            mode_next   = MODE_IDLE;
                        end
                    end
                    MODE_CMD_WAIT:
                    begin
                        tick_next = tick_inc;
                        if (tick_reg > cfg.command_timeout_ticks)
                        begin
                            tick_next    = 16'd0;
                            request_next = 1'b0;
                            result_next  = RES_TIMEOUT;
                            mode_next    = MODE_IDLE;
                        end
                    end
                    MODE_CMD_RESP:
                    begin
                        result_next = RES_SUCCESS;
                        mode_next   = MODE_IDLE;
                    end
                    MODE_RSP_READY:
                    begin
                        if (stop_reg)
                        begin
                            if (rx_count_reg != 2'd0)
                            begin
                                if (name_match)
                                begin
                                    run.tx_bytes[0] = RSP_OK_LEAD;
                                    run.tx_bytes[1] = RSP_OK_CODE;
                                    run.tx_bytes[2] = cfg.protocol_version;
                                    run.byte_count  = 3'd3;
                                end
                                else
                                begin
                                    run.tx_bytes[0] = RSP_FAIL_BYTE;
                                    run.tx_bytes[1] = RSP_FAIL_BYTE;
                                    run.byte_count  = 3'd2;
                                end
                                request_next  = 1'b1;
                                rx_count_next = 2'd0;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                            stop_next = 1'b0;
                        end
                    end
                    MODE_RSP_DONE:
                    begin
                        if (stop_reg)
                            mode_next = MODE_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_SEND:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    run.tx_bytes[0] = FRAME_START;
                    run.tx_bytes[1] = item.command_first_char;
                    run.tx_bytes[2] = item.command_second_char;
                    run.tx_bytes[3] = item.command_argument;
                    run.byte_count  = 3'd4;
                    request_next    = 1'b1;
                    tick_next       = 16'd0;
                    mode_next       = MODE_CMD_WAIT;
                    acc             = 1'b1;
                end
            end
            FUNC_POWER:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    mode_next = MODE_PWR_REQ;
                    acc       = 1'b1;
                end
            end
            FUNC_ADDRESSED:
            begin
                if (item.read_direction)
                begin
                    if (mode_reg == MODE_CMD_WAIT)
                    begin
                        request_next = 1'b0;
                        mode_next    = MODE_CMD_RESP;
                    end
                    else if (mode_reg == MODE_RSP_READY)
                    begin
                        request_next = 1'b0;
                        mode_next    = MODE_RSP_DONE;
                    end
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    mode_next     = MODE_RSP_READY;
                    stop_next     = 1'b0;
                    rx_count_next = 2'd0;
                end
            end
            FUNC_RX_BYTE:
            begin
                if (rx_count_reg < RX_KEEP)
                begin
                    rx_write      = 1'b1;
                    rx_count_next = rx_count_reg + 2'd1;
                end
            end
            FUNC_STOP:
            begin
                stop_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        // status after this item
        run.status.accepted             = acc;
        run.status.request_line         = request_next;
        run.status.power_button_pressed = button_next;
        run.status.power_status = (mode_next == MODE_PWR_REQ || mode_next == MODE_PWR_WAIT)
                                ? PSTAT_WAIT : {1'b0, item.power_sense};
        run.status.last_result          = result_next;
        run.status.ready_for_command    = (mode_next == MODE_IDLE) && !item.bus_busy;
        run.status.control_state        = mode_next;
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            tick_reg     <= 16'd0;
            result_reg   <= RES_UNKNOWN;
            stop_reg     <= 1'b0;
            rx_count_reg <= 2'd0;
            request_reg  <= 1'b0;
            button_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            result_reg   <= result_next;
            stop_reg     <= stop_next;
            rx_count_reg <= rx_count_next;
            request_reg  <= request_next;
            button_reg   <= button_next;
        end
    end

    // received command bytes
    always_ff @(posedge clk)
    begin
        if (accept && rx_write)
            rx_bytes_reg[rx_count_reg] <= item.received_byte;
    end

endmodule

FILE: sv/cbac_queue.sv
// ----------------------------------------------------------------------------
// cbac_queue
// Small FIFO of runs between the front and the back.
// ----------------------------------------------------------------------------
module cbac_queue #(
    parameter int DEPTH = cbac_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbac_pkg::run_t push_data,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output cbac_pkg::run_t pop_data
);
    import cbac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    run_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: sv/cbac_back.sv
// ----------------------------------------------------------------------------
// cbac_back
// Plays each run out as one result per transmit byte, or one bare status.
// ----------------------------------------------------------------------------
module cbac_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              run_valid,
    input  cbac_pkg::run_t    run,
    output logic              run_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output cbac_pkg::result_t result
);
    import cbac_pkg::*;

    run_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic [2:0] total;
    logic       last;
    logic       take;
    logic       load;

    assign total = (cur_reg.byte_count == 3'd0) ? 3'd1 : cur_reg.byte_count;
    assign last  = ({1'b0, idx_reg} == total - 3'd1);
    assign take  = result_valid && !result_stall;
    assign load  = run_valid && (!cur_valid_reg || (take && last));

    assign run_pop      = load;
    assign result_valid = cur_valid_reg;

    // result fields from the held run
    always_comb
    begin
        result.tx_valid             = (cur_reg.byte_count != 3'd0);
        result.tx_data              = result.tx_valid ? cur_reg.tx_bytes[idx_reg] : 8'd0;
        result.last_of_run          = last;
        result.accepted             = cur_reg.status.accepted;
        result.request_line         = cur_reg.status.request_line;
        result.power_button_pressed = cur_reg.status.power_button_pressed;
        result.power_status         = cur_reg.status.power_status;
        result.last_result          = cur_reg.status.last_result;
        result.ready_for_command    = cur_reg.status.ready_for_command;
        result.control_state        = cur_reg.status.control_state;
    end

    // held run
    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= run;
    end

    // occupancy and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (take)
        begin
            if (last)
                cur_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

FILE: sv/camera_bus_accessory_controller_unit.sv
// ----------------------------------------------------------------------------
// camera_bus_accessory_controller_unit
// Accessory side of a camera command link: control machine, run queue,
// result serializer and APB configuration registers.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while the run queue has room and updates
// the control state at once; every item leaves one run in the queue. The back
// turns a run into results at one per cycle while the result channel does not
// stall: four results for a send command, three for a version reply, two for a
// failure reply and one for every other item. Sustained rate is therefore set
// by the back's byte serializer, and the queue (QUEUE_DEPTH runs) lets the
// front keep accepting while the back is stalled until the queue fills.
module camera_bus_accessory_controller_unit #(
    parameter int QUEUE_DEPTH = cbac_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbac_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbac_pkg::DATA_W-1:0]   pwdata,
    output logic [cbac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  cbac_pkg::item_t               item,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output cbac_pkg::result_t             result
);
    import cbac_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    reg_index_t reg_sel;
    logic       queue_full;
    logic       run_push;
    run_t       run_in;
    logic       run_valid;
    logic       run_pop;
    run_t       run_out;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_press_ticks     <= POWER_PRESS_RESET;
            cfg_reg.command_timeout_ticks <= CMD_TIMEOUT_RESET;
            cfg_reg.protocol_version      <= PROTO_VERSION_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_POWER_PRESS:   cfg_reg.power_press_ticks     <= pwdata[15:0];
                REG_CMD_TIMEOUT:   cfg_reg.command_timeout_ticks <= pwdata[15:0];
                REG_PROTO_VERSION: cfg_reg.protocol_version      <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            REG_POWER_PRESS:   prdata = {16'd0, cfg_reg.power_press_ticks};
            REG_CMD_TIMEOUT:   prdata = {16'd0, cfg_reg.command_timeout_ticks};
            REG_PROTO_VERSION: prdata = {24'd0, cfg_reg.protocol_version};
            default:           prdata = '0;
        endcase
    end

    // front: control machine
    cbac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .run_push   (run_push),
        .run        (run_in)
    );

    // run queue
    cbac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (run_push),
        .push_data (run_in),
        .full      (queue_full),
        .pop_valid (run_valid),
        .pop       (run_pop),
        .pop_data  (run_out)
    );

    // back: result serializer
    cbac_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_valid    (run_valid),
        .run          (run_out),
        .run_pop      (run_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: dv/camera_bus_accessory_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_bus_accessory_controller_unit_test
// Self-checking bench for the camera bus accessory controller. A cycle-free
// predictor of the control machine runs on every item transaction taken by
// the block and queues the result transactions it must produce. A monitor
// checks every result, field by field, in order. Directed tests cover the
// command handshake, limit extremes, partner commands and maximum hold
// limits. A back-pressure test and randomized protocol sequences follow.
// ----------------------------------------------------------------------------
module camera_bus_accessory_controller_unit_test;
    import cbac_pkg::*;

    // func codes with no operation behind them
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid = 1'b0;
    logic                item_stall;
    item_t               item = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;

    // predicted controller state and its configuration
    mode_t               ctl_mode = MODE_IDLE;
    logic [15:0]         hold_ticks = '0;
    result_code_t        last_res = RES_UNKNOWN;
    logic                stop_seen = 1'b0;
    logic [1:0]          rx_cnt = '0;
    logic [7:0]          rx_buf [3] = '{8'd0, 8'd0, 8'd0};
    logic                req_lvl = 1'b0;
    logic                btn_lvl = 1'b0;
    logic [15:0]         cfg_press = POWER_PRESS_RESET;
    logic [15:0]         cfg_timeout = CMD_TIMEOUT_RESET;
    logic [7:0]          cfg_version = PROTO_VERSION_RESET;

    result_t             results_due [$];
    int                  mismatches = 0;
    int                  items_sent = 0;
    bit                  idling_on = 1'b1;
    int                  stall_hold_req = 0;

    camera_bus_accessory_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Control machine predictor
    // ------------------------------------------------------------------
    // bump the hold counter, saturating; true once the old count passed limit
    function automatic logic tick_past(input logic [15:0] limit);
        logic [15:0] old_v;
        old_v = hold_ticks;
        if (hold_ticks != TICK_MAX)
            hold_ticks++;
        return old_v > limit;
    endfunction

    task automatic advance_control_state(input item_t it);
        logic [7:0] bytes_out [$];
        logic       took;
        logic       name_v;
        logic       name_s;
        result_t    r;
        int         runs;
        took = 1'b0;
        case (it.func)
            FUNC_TICK: begin
                case (ctl_mode)
                    MODE_PWR_REQ: begin
                        btn_lvl = 1'b1;
                        hold_ticks = '0;
                        ctl_mode = MODE_PWR_WAIT;
                    end
                    MODE_PWR_WAIT: begin
                        if (tick_past(cfg_press)) begin
                            btn_lvl = 1'b0;
                            ctl_mode = MODE_IDLE;
                        end
                    end
                    MODE_CMD_WAIT: begin
                        if (tick_past(cfg_timeout)) begin
                            hold_ticks = '0;
                            req_lvl = 1'b0;
                            last_res = RES_TIMEOUT;
                            ctl_mode = MODE_IDLE;
                        end
                    end
                    MODE_CMD_RESP: begin
                        last_res = RES_SUCCESS;
                        ctl_mode = MODE_IDLE;
                    end
                    MODE_RSP_READY: begin
                        if (stop_seen) begin
                            if (rx_cnt != 2'd0) begin
                                // length byte must cover each name char
                                name_v = rx_cnt >= 2'd2 && rx_buf[0] >= 8'd1
                                         && rx_buf[1] == CHAR_V;
                                name_s = rx_cnt >= 2'd3 && rx_buf[0] >= 8'd2
                                         && rx_buf[2] == CHAR_S;
                                if (name_v && name_s)
                                    bytes_out = '{RSP_OK_LEAD, RSP_OK_CODE, cfg_version};
                                else
                                    bytes_out = '{RSP_FAIL_BYTE, RSP_FAIL_BYTE};
                                req_lvl = 1'b1;
                                rx_cnt = '0;
                            end
                            else begin
                                ctl_mode = MODE_IDLE;
                            end
                            stop_seen = 1'b0;
                        end
                    end
                    MODE_RSP_DONE: begin
                        if (stop_seen)
                            ctl_mode = MODE_IDLE;
                    end
                    default: ;
                endcase
            end
            FUNC_SEND: begin
                if (ctl_mode == MODE_IDLE) begin
                    bytes_out = '{FRAME_START, it.command_first_char,
                                  it.command_second_char, it.command_argument};
                    req_lvl = 1'b1;
                    hold_ticks = '0;
                    ctl_mode = MODE_CMD_WAIT;
                    took = 1'b1;
                end
            end
            FUNC_POWER: begin
                if (ctl_mode == MODE_IDLE) begin
                    ctl_mode = MODE_PWR_REQ;
                    took = 1'b1;
                end
            end
            FUNC_ADDRESSED: begin
                if (it.read_direction) begin
                    if (ctl_mode == MODE_CMD_WAIT) begin
                        req_lvl = 1'b0;
                        ctl_mode = MODE_CMD_RESP;
                    end
                    else if (ctl_mode == MODE_RSP_READY) begin
                        req_lvl = 1'b0;
                        ctl_mode = MODE_RSP_DONE;
                    end
                end
                else if (ctl_mode == MODE_IDLE) begin
                    ctl_mode = MODE_RSP_READY;
                    stop_seen = 1'b0;
                    rx_cnt = '0;
                end
            end
            FUNC_RX_BYTE: begin
                if (rx_cnt < RX_KEEP) begin
                    rx_buf[rx_cnt] = it.received_byte;
                    rx_cnt++;
                end
            end
            FUNC_STOP: stop_seen = 1'b1;
            default: ;
        endcase

        // one result per queued byte, else a single status result
        runs = (bytes_out.size() > 0) ? bytes_out.size() : 1;
        for (int k = 0; k < runs; k++) begin
            r.tx_valid             = bytes_out.size() > 0;
            r.tx_data              = (bytes_out.size() > 0) ? bytes_out[k] : 8'd0;
            r.last_of_run          = (k == runs - 1);
            r.accepted             = took;
            r.request_line         = req_lvl;
            r.power_button_pressed = btn_lvl;
            r.power_status         = (ctl_mode == MODE_PWR_REQ || ctl_mode == MODE_PWR_WAIT)
                                     ? PSTAT_WAIT : {1'b0, it.power_sense};
            r.last_result          = last_res;
            r.ready_for_command    = (ctl_mode == MODE_IDLE) && !it.bus_busy;
            r.control_state        = ctl_mode;
            results_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %0h with none outstanding", result));
            end
            else begin
                want = results_due.pop_front();
                check_field("tx_valid", result.tx_valid, want.tx_valid);
                check_field("tx_data", result.tx_data, want.tx_data);
                check_field("last_of_run", result.last_of_run, want.last_of_run);
                check_field("accepted", result.accepted, want.accepted);
                check_field("request_line", result.request_line, want.request_line);
                check_field("power_button_pressed", result.power_button_pressed,
                            want.power_button_pressed);
                check_field("power_status", result.power_status, want.power_status);
                check_field("last_result", result.last_result, want.last_result);
                check_field("ready_for_command", result.ready_for_command,
                            want.ready_for_command);
                check_field("control_state", result.control_state, want.control_state);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall driver: random stretches, or a requested long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_stall_driver
        logic level;
        int   span;
        int   r;
        forever begin
            if (stall_hold_req > 0) begin
                level = 1'b1;
                span = stall_hold_req;
                stall_hold_req = 0;
            end
            else if (!idling_on) begin
                level = 1'b0;
                span = 1;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    level = 1'b0;
                    span = $urandom_range(1, 12);
                end
                else if (r < 92) begin
                    level = 1'b1;
                    span = $urandom_range(1, 3);
                end
                else begin
                    level = 1'b1;
                    span = $urandom_range(8, 40);
                end
            end
            result_stall <= level;
            repeat (span) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Item transaction driver and helpers
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it);
        int gap;
        int r;
        gap = 0;
        if (idling_on) begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 30);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        advance_control_state(it);
        items_sent++;
    endtask

    function automatic item_t rand_item(input logic [2:0] f);
        item_t it;
        it.func                = f;
        it.command_first_char  = 8'($urandom);
        it.command_second_char = 8'($urandom);
        it.command_argument    = 8'($urandom);
        it.read_direction      = 1'($urandom);
        it.received_byte       = 8'($urandom);
        it.bus_busy            = 1'($urandom);
        it.power_sense         = 1'($urandom);
        return it;
    endfunction

    // mostly the expected char, sometimes anything
    function automatic logic [7:0] pick_char(input logic [7:0] c);
        return ($urandom_range(0, 9) < 7) ? c : 8'($urandom);
    endfunction

    task automatic issue(input logic [2:0] f);
        send_item(rand_item(f));
    endtask

    task automatic issue_addressed(input logic rd);
        item_t it;
        it = rand_item(FUNC_ADDRESSED);
        it.read_direction = rd;
        send_item(it);
    endtask

    task automatic issue_byte(input logic [7:0] b);
        item_t it;
        it = rand_item(FUNC_RX_BYTE);
        it.received_byte = b;
        send_item(it);
    endtask

    task automatic issue_send(input logic [7:0] c1, input logic [7:0] c2,
                              input logic [7:0] arg);
        item_t it;
        it = rand_item(FUNC_SEND);
        it.command_first_char  = c1;
        it.command_second_char = c2;
        it.command_argument    = arg;
        send_item(it);
    endtask

    // partner reads the queued reply, ends with a stop, block returns to idle
    task automatic finish_reply();
        issue_addressed(1'b1);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
    endtask

    // let every outstanding result through, then wait with the item input idle
    task automatic drain();
        item_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_POWER_PRESS:   cfg_press = value[15:0];
            REG_CMD_TIMEOUT:   cfg_timeout = value[15:0];
            REG_PROTO_VERSION: cfg_version = value[7:0];
            default: ;
        endcase
    endtask

    // steer the controller back to idle from wherever it is
    task automatic settle_to_idle();
        int guard;
        guard = 0;
        while (ctl_mode != MODE_IDLE && guard < 40) begin
            guard++;
            case (ctl_mode)
                MODE_CMD_WAIT: issue_addressed(1'b1);
                MODE_RSP_READY: begin
                    if (req_lvl)
                        issue_addressed(1'b1);
                    else if (!stop_seen)
                        issue(FUNC_STOP);
                    else
                        issue(FUNC_TICK);
                end
                MODE_RSP_DONE: begin
                    if (!stop_seen)
                        issue(FUNC_STOP);
                    else
                        issue(FUNC_TICK);
                end
                default: issue(FUNC_TICK);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // status reporting, command send and refusal, read-out with reset config
    task automatic test_command_handshake();
        item_t it;
        it = rand_item(FUNC_TICK);
        it.bus_busy = 1'b0;
        it.power_sense = 1'b0;
        send_item(it);
        it.bus_busy = 1'b1;
        it.power_sense = 1'b1;
        send_item(it);
        issue(FUNC_SPARE_A);
        issue(FUNC_SPARE_B);
        issue_send(8'h00, 8'hFF, 8'h00);
        // requests outside idle are refused
        issue_send(8'hFF, 8'h00, 8'hFF);
        issue(FUNC_POWER);
        issue_addressed(1'b0);
        issue_addressed(1'b1);
        issue(FUNC_TICK);
        drain();
    endtask

    // zero hold limits: shortest timeout and shortest button press
    task automatic test_limit_extremes();
        write_reg(REG_POWER_PRESS, 32'd0);
        write_reg(REG_CMD_TIMEOUT, 32'd0);
        write_reg(REG_PROTO_VERSION, 32'd255);
        issue_send(CHAR_V, CHAR_S, 8'h80);
        issue(FUNC_TICK);
        issue(FUNC_TICK);
        issue(FUNC_POWER);
        repeat (3) issue(FUNC_TICK);
        drain();
    endtask

    // partner-written commands: version query, failures, overflow, empty
    task automatic test_partner_commands();
        issue(FUNC_STOP);
        issue_addressed(1'b1);
        issue(FUNC_TICK);
        // version query
        issue_addressed(1'b0);
        issue_byte(8'd2);
        issue_byte(CHAR_V);
        issue_byte(CHAR_S);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
        finish_reply();
        // extra bytes past the third are dropped
        issue_addressed(1'b0);
        issue_byte(8'd2);
        issue_byte(CHAR_V);
        issue_byte(CHAR_S);
        issue_byte(8'h55);
        issue_byte(8'hAA);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
        finish_reply();
        // length byte too short for the second char
        issue_addressed(1'b0);
        issue_byte(8'd1);
        issue_byte(CHAR_V);
        issue_byte(CHAR_S);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
        finish_reply();
        // second char never arrives
        issue_addressed(1'b0);
        issue_byte(8'd2);
        issue_byte(CHAR_V);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
        finish_reply();
        // stop with nothing received
        issue_addressed(1'b0);
        issue(FUNC_STOP);
        issue(FUNC_TICK);
        drain();
    endtask

    // maximum limits hold the wait and the press until the limit drops
    task automatic test_max_limits();
        idling_on = 1'b0;
        write_reg(REG_CMD_TIMEOUT, 32'd65535);
        write_reg(REG_POWER_PRESS, 32'd65535);
        write_reg(REG_PROTO_VERSION, 32'd0);
        issue_send(8'($urandom), 8'($urandom), 8'($urandom));
        repeat (20) issue(FUNC_TICK);
        drain();
        write_reg(REG_CMD_TIMEOUT, 32'd10);
        issue(FUNC_TICK);
        // maximum press limit holds the button until the limit drops
        issue(FUNC_POWER);
        repeat (6) issue(FUNC_TICK);
        drain();
        write_reg(REG_POWER_PRESS, 32'd0);
        issue(FUNC_TICK);
        drain();
        idling_on = 1'b1;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_back_pressure();
        idling_on = 1'b0;
        stall_hold_req = 200;
        repeat (10) begin
            issue_send(8'($urandom), 8'($urandom), 8'($urandom));
            issue_addressed(1'b1);
            issue(FUNC_TICK);
        end
        drain();
        idling_on = 1'b1;
    endtask

    // one randomized protocol sequence, or a burst of noise
    task automatic run_scenario();
        int r;
        int nb;
        int guard;
        logic [7:0] b;
        settle_to_idle();
        idling_on = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 99);
        if (r < 32) begin
            // partner writes a command and reads the reply
            issue_addressed(1'b0);
            nb = ($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 5);
            for (int i = 0; i < nb; i++) begin
                case (i)
                    0: b = ($urandom_range(0, 1)) ? 8'd2
                          : ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    1: b = pick_char(CHAR_V);
                    2: b = pick_char(CHAR_S);
                    default: b = 8'($urandom);
                endcase
                issue_byte(b);
                if ($urandom_range(0, 7) == 0)
                    issue(FUNC_TICK);
            end
            issue(FUNC_STOP);
            issue(FUNC_TICK);
            if (ctl_mode == MODE_RSP_READY && req_lvl) begin
                repeat ($urandom_range(0, 2)) issue(FUNC_TICK);
                finish_reply();
            end
        end
        else if (r < 57) begin
            // command send, then read out or time out
            issue_send(pick_char(CHAR_V), pick_char(CHAR_S), 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                issue($urandom_range(0, 1) ? FUNC_POWER : FUNC_SEND);
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(0, 3)) issue(FUNC_TICK);
                issue_addressed(1'b1);
                issue(FUNC_TICK);
            end
            else begin
                guard = 0;
                while (ctl_mode == MODE_CMD_WAIT && guard < 40) begin
                    guard++;
                    issue(FUNC_TICK);
                end
            end
        end
        else if (r < 77) begin
            // power button press held for the configured ticks
            issue(FUNC_POWER);
            guard = 0;
            while ((ctl_mode == MODE_PWR_REQ || ctl_mode == MODE_PWR_WAIT) && guard < 40) begin
                guard++;
                issue($urandom_range(0, 5) == 0 ? 3'($urandom_range(1, 7)) : FUNC_TICK);
            end
        end
        else begin
            repeat ($urandom_range(1, 6)) issue(3'($urandom_range(0, 7)));
        end
        idling_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int phase_start;
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_reg(REG_POWER_PRESS, 32'($urandom_range(0, 6)));
            write_reg(REG_CMD_TIMEOUT, 32'($urandom_range(0, 10)));
            write_reg(REG_PROTO_VERSION, 32'($urandom_range(0, 255)));
            phase_start = items_sent;
            while (items_sent - phase_start < 25)
                run_scenario();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_command_handshake();
        test_limit_extremes();
        test_partner_commands();
        test_max_limits();
        test_back_pressure();
        test_random_sequences();
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // overall time limit
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
sv/cbac_pkg.sv
sv/cbac_front.sv
sv/cbac_queue.sv
sv/cbac_back.sv
sv/camera_bus_accessory_controller_unit.sv
dv/camera_bus_accessory_controller_unit_test.sv
